// ===== hdl/obb_pkg.sv =====
// Shared constants and types for the oriented-box overlap pipeline.
// No dependencies; used by obb_core, obb_overlap_test and the checker.
`default_nettype none
package obb_pkg;

   // Default fixed-point shape of one packed component
   localparam int DEF_COMPONENT_WIDTH    = 16;
   localparam int DEF_AXIS_FRACTION_BITS = 14;

   // Register stages from input word to result word
   localparam int NUM_STAGES = 6;

   // Cyclic neighbours of a component index, used for cross products
   localparam int NXT1 [3] = '{1, 2, 0};
   localparam int NXT2 [3] = '{2, 0, 1};

   // Per-stage load enables from the handshake control to the datapath
   typedef struct packed {
      logic [NUM_STAGES-1:0] adv;
   } pipe_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/obb_core.sv =====
// Datapath of the 15-axis separating test, six register stages.
// Depends on obb_pkg; stage enables come from obb_overlap_test.
`default_nettype none
module obb_core #(
   parameter int COMPONENT_WIDTH    = obb_pkg::DEF_COMPONENT_WIDTH,
   parameter int AXIS_FRACTION_BITS = obb_pkg::DEF_AXIS_FRACTION_BITS
) (
   input  wire logic                         clock,
   input  wire obb_pkg::pipe_ctrl_type       ctrl,
   input  wire logic [3*COMPONENT_WIDTH-1:0] a_center,
   input  wire logic [3*COMPONENT_WIDTH-1:0] a_axis0,
   input  wire logic [3*COMPONENT_WIDTH-1:0] a_axis1,
   input  wire logic [3*COMPONENT_WIDTH-1:0] a_axis2,
   input  wire logic [3*COMPONENT_WIDTH-1:0] a_half_lengths,
   input  wire logic [3*COMPONENT_WIDTH-1:0] b_center,
   input  wire logic [3*COMPONENT_WIDTH-1:0] b_axis0,
   input  wire logic [3*COMPONENT_WIDTH-1:0] b_axis1,
   input  wire logic [3*COMPONENT_WIDTH-1:0] b_axis2,
   input  wire logic [3*COMPONENT_WIDTH-1:0] b_half_lengths,
   output logic                              overlap
);
   import obb_pkg::*;

   localparam int W   = COMPONENT_WIDTH;
   localparam int F   = AXIS_FRACTION_BITS;
   localparam int PW  = 2*W;          // component product
   localparam int DW  = 2*W + 2;      // axis dot axis
   localparam int RW  = DW + 1 - F;   // rounded axis dot magnitude
   localparam int XW  = 2*W + 1;      // cross component before rounding
   localparam int CW  = 2*W + 3 - F;  // rounded cross component, signed
   localparam int DPW = 2*W + 1;      // centre diff times axis component
   localparam int FLW = 2*W + 3;      // face axis centre projection
   localparam int CPW = W + CW;       // axis component times cross component
   localparam int PJW = CPW + 2;      // axis dot cross axis
   localparam int PRW = PJW + 1 - F;  // rounded projection magnitude
   localparam int DCW = W + 1 + CW;   // centre diff times cross component
   localparam int CLW = DCW + 2;      // cross axis centre projection
   localparam int SW  = W + PRW + 3;  // common compare width
   localparam logic [PJW:0] HALF_PJ = (PJW+1)'(1) << (F-1);
   localparam logic [DW:0]  HALF_D  = (DW+1)'(1) << (F-1);
   localparam logic [XW:0]  HALF_X  = (XW+1)'(1) << (F-1);

   // Unpack the input word: box, axis, component
   logic signed [W-1:0] ax_w [2][3][3];
   logic        [W-1:0] h_w  [2][3];
   logic signed [W-1:0] ca_w [3];
   logic signed [W-1:0] cb_w [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ca_w[k]         = a_center[k*W +: W];
         cb_w[k]         = b_center[k*W +: W];
         ax_w[0][0][k]   = a_axis0[k*W +: W];
         ax_w[0][1][k]   = a_axis1[k*W +: W];
         ax_w[0][2][k]   = a_axis2[k*W +: W];
         ax_w[1][0][k]   = b_axis0[k*W +: W];
         ax_w[1][1][k]   = b_axis1[k*W +: W];
         ax_w[1][2][k]   = b_axis2[k*W +: W];
         h_w[0][k]       = a_half_lengths[k*W +: W];
         h_w[1][k]       = b_half_lengths[k*W +: W];
      end
   end

   // Stage 1: centre difference, axis-pair and cross-term products
   logic signed [W:0]    s1_d_in   [3];
   logic signed [W:0]    s1_d_ff   [3];
   logic signed [PW-1:0] s1_pab_in [3][3][3];
   logic signed [PW-1:0] s1_pab_ff [3][3][3];
   logic signed [PW-1:0] s1_px_in  [3][3][3][2];
   logic signed [PW-1:0] s1_px_ff  [3][3][3][2];
   logic signed [W-1:0]  s1_ax_ff  [2][3][3];
   logic        [W-1:0]  s1_h_ff   [2][3];

   always_comb begin
      for (int k = 0; k < 3; k++)
         s1_d_in[k] = (W+1)'(ca_w[k]) - (W+1)'(cb_w[k]);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int m = 0; m < 3; m++) begin
               s1_pab_in[i][j][m]   = PW'(ax_w[0][i][m]) * PW'(ax_w[1][j][m]);
               s1_px_in[i][j][m][0] = PW'(ax_w[0][i][NXT1[m]]) * PW'(ax_w[1][j][NXT2[m]]);
               s1_px_in[i][j][m][1] = PW'(ax_w[0][i][NXT2[m]]) * PW'(ax_w[1][j][NXT1[m]]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         s1_d_ff   <= s1_d_in;
         s1_pab_ff <= s1_pab_in;
         s1_px_ff  <= s1_px_in;
         s1_ax_ff  <= ax_w;
         s1_h_ff   <= h_w;
      end
   end

   // Stage 2: rounded axis dots, rounded cross axes, centre-diff products
   logic        [RW-1:0]  s2_r_in  [3][3];
   logic        [RW-1:0]  s2_r_ff  [3][3];
   logic signed [CW-1:0]  s2_c_in  [3][3][3];
   logic signed [CW-1:0]  s2_c_ff  [3][3][3];
   logic signed [DPW-1:0] s2_pd_in [2][3][3];
   logic signed [DPW-1:0] s2_pd_ff [2][3][3];
   logic signed [W:0]     s2_d_ff  [3];
   logic signed [W-1:0]   s2_ax_ff [2][3][3];
   logic        [W-1:0]   s2_h_ff  [2][3];

   always_comb begin
      logic signed [DW-1:0] dot;
      logic        [DW-1:0] dm;
      logic        [DW:0]   dr;
      logic signed [XW-1:0] xv;
      logic        [XW-1:0] xm;
      logic        [XW:0]   xr;
      logic signed [CW-1:0] cr;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            dot = DW'(s1_pab_ff[i][j][0]) + DW'(s1_pab_ff[i][j][1])
                + DW'(s1_pab_ff[i][j][2]);
            dm  = dot[DW-1] ? DW'(-dot) : DW'(dot);
            dr  = (DW+1)'(dm) + HALF_D;
            s2_r_in[i][j] = dr[DW:F];
            for (int m = 0; m < 3; m++) begin
               xv = XW'(s1_px_ff[i][j][m][0]) - XW'(s1_px_ff[i][j][m][1]);
               xm = xv[XW-1] ? XW'(-xv) : XW'(xv);
               xr = (XW+1)'(xm) + HALF_X;
               cr = signed'(CW'(xr[XW:F]));
               s2_c_in[i][j][m] = xv[XW-1] ? -cr : cr;
            end
         end
      end
      for (int b = 0; b < 2; b++)
         for (int n = 0; n < 3; n++)
            for (int k = 0; k < 3; k++)
               s2_pd_in[b][n][k] = DPW'(s1_d_ff[k]) * DPW'(s1_ax_ff[b][n][k]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[1]) begin
         s2_r_ff  <= s2_r_in;
         s2_c_ff  <= s2_c_in;
         s2_pd_ff <= s2_pd_in;
         s2_d_ff  <= s1_d_ff;
         s2_ax_ff <= s1_ax_ff;
         s2_h_ff  <= s1_h_ff;
      end
   end

   // Stage 3: face projections, face radius terms, cross projection products
   logic        [FLW-1:0]  s3_lf_in  [2][3];
   logic        [FLW-1:0]  s3_lf_ff  [2][3];
   logic        [W+RW-1:0] s3_tf_in  [2][3][3];
   logic        [W+RW-1:0] s3_tf_ff  [2][3][3];
   logic signed [CPW-1:0]  s3_pj_in  [2][3][3][3][3];
   logic signed [CPW-1:0]  s3_pj_ff  [2][3][3][3][3];
   logic signed [DCW-1:0]  s3_pdc_in [3][3][3];
   logic signed [DCW-1:0]  s3_pdc_ff [3][3][3];
   logic        [W-1:0]    s3_h_ff   [2][3];

   always_comb begin
      logic signed [FLW-1:0] fl;
      for (int b = 0; b < 2; b++) begin
         for (int n = 0; n < 3; n++) begin
            fl = FLW'(s2_pd_ff[b][n][0]) + FLW'(s2_pd_ff[b][n][1])
               + FLW'(s2_pd_ff[b][n][2]);
            s3_lf_in[b][n] = fl[FLW-1] ? FLW'(-fl) : FLW'(fl);
            for (int k = 0; k < 3; k++) begin
               // other box's radius: its axes dotted with this face axis
               if (b == 0)
                  s3_tf_in[b][n][k] = (W+RW)'(s2_h_ff[1][k]) * (W+RW)'(s2_r_ff[n][k]);
               else
                  s3_tf_in[b][n][k] = (W+RW)'(s2_h_ff[0][k]) * (W+RW)'(s2_r_ff[k][n]);
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int m = 0; m < 3; m++) begin
               s3_pdc_in[i][j][m] = DCW'(s2_d_ff[m]) * DCW'(s2_c_ff[i][j][m]);
               for (int b = 0; b < 2; b++)
                  for (int k = 0; k < 3; k++)
                     s3_pj_in[b][i][j][k][m] =
                        CPW'(s2_ax_ff[b][k][m]) * CPW'(s2_c_ff[i][j][m]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[2]) begin
         s3_lf_ff  <= s3_lf_in;
         s3_tf_ff  <= s3_tf_in;
         s3_pj_ff  <= s3_pj_in;
         s3_pdc_ff <= s3_pdc_in;
         s3_h_ff   <= s2_h_ff;
      end
   end

   // Stage 4: face axis verdicts, rounded cross projections
   logic              s4_fsep_in;
   logic              s4_fsep_ff;
   logic [PRW-1:0]    s4_pr_in [2][3][3][3];
   logic [PRW-1:0]    s4_pr_ff [2][3][3][3];
   logic [CLW-1:0]    s4_lc_in [3][3];
   logic [CLW-1:0]    s4_lc_ff [3][3];
   logic [W-1:0]      s4_h_ff  [2][3];

   always_comb begin
      logic        [SW-1:0]  rad;
      logic signed [PJW-1:0] pj;
      logic        [PJW-1:0] pm;
      logic        [PJW:0]   pr;
      logic signed [CLW-1:0] lc;
      s4_fsep_in = 1'b0;
      for (int b = 0; b < 2; b++) begin
         for (int n = 0; n < 3; n++) begin
            rad = SW'({s3_h_ff[b][n], {F{1'b0}}}) + SW'(s3_tf_ff[b][n][0])
                + SW'(s3_tf_ff[b][n][1]) + SW'(s3_tf_ff[b][n][2]);
            if (SW'(s3_lf_ff[b][n]) > rad)
               s4_fsep_in = 1'b1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            lc = CLW'(s3_pdc_ff[i][j][0]) + CLW'(s3_pdc_ff[i][j][1])
               + CLW'(s3_pdc_ff[i][j][2]);
            s4_lc_in[i][j] = lc[CLW-1] ? CLW'(-lc) : CLW'(lc);
            for (int b = 0; b < 2; b++) begin
               for (int k = 0; k < 3; k++) begin
                  pj = PJW'(s3_pj_ff[b][i][j][k][0]) + PJW'(s3_pj_ff[b][i][j][k][1])
                     + PJW'(s3_pj_ff[b][i][j][k][2]);
                  pm = pj[PJW-1] ? PJW'(-pj) : PJW'(pj);
                  pr = (PJW+1)'(pm) + HALF_PJ;
                  s4_pr_in[b][i][j][k] = pr[PJW:F];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[3]) begin
         s4_fsep_ff <= s4_fsep_in;
         s4_pr_ff   <= s4_pr_in;
         s4_lc_ff   <= s4_lc_in;
         s4_h_ff    <= s3_h_ff;
      end
   end

   // Stage 5: cross axis radius terms, two axes of each box
   logic [W+PRW-1:0] s5_t_in [3][3][4];
   logic [W+PRW-1:0] s5_t_ff [3][3][4];
   logic [CLW-1:0]   s5_lc_ff [3][3];
   logic             s5_fsep_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s5_t_in[i][j][0] = (W+PRW)'(s4_h_ff[0][NXT1[i]])
                             * (W+PRW)'(s4_pr_ff[0][i][j][NXT1[i]]);
            s5_t_in[i][j][1] = (W+PRW)'(s4_h_ff[0][NXT2[i]])
                             * (W+PRW)'(s4_pr_ff[0][i][j][NXT2[i]]);
            s5_t_in[i][j][2] = (W+PRW)'(s4_h_ff[1][NXT1[j]])
                             * (W+PRW)'(s4_pr_ff[1][i][j][NXT1[j]]);
            s5_t_in[i][j][3] = (W+PRW)'(s4_h_ff[1][NXT2[j]])
                             * (W+PRW)'(s4_pr_ff[1][i][j][NXT2[j]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[4]) begin
         s5_t_ff    <= s5_t_in;
         s5_lc_ff   <= s4_lc_ff;
         s5_fsep_ff <= s4_fsep_ff;
      end
   end

   // Stage 6: cross axis verdicts, final result word
   logic s6_overlap_in;
   logic s6_overlap_ff;

   always_comb begin
      logic [SW-1:0] rad;
      logic          sep;
      sep = s5_fsep_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rad = SW'(s5_t_ff[i][j][0]) + SW'(s5_t_ff[i][j][1])
                + SW'(s5_t_ff[i][j][2]) + SW'(s5_t_ff[i][j][3]);
            if (SW'(s5_lc_ff[i][j]) > rad)
               sep = 1'b1;
         end
      end
      s6_overlap_in = !sep;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[5]) begin
         s6_overlap_ff <= s6_overlap_in;
      end
   end

   assign overlap = s6_overlap_ff;

endmodule
`default_nettype wire

// ===== hdl/obb_overlap_test.sv =====
// Each accepted req word passes through the six datapath stages to its rsp word.
// Throughput: one box pair per cycle unless rsp_stall holds a full pipeline.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up and new words are taken while a result waits on rsp_stall.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
// Top level of the oriented-box overlap test; depends on obb_pkg and obb_core.
`default_nettype none
module obb_overlap_test #(
   parameter int COMPONENT_WIDTH    = obb_pkg::DEF_COMPONENT_WIDTH,
   parameter int AXIS_FRACTION_BITS = obb_pkg::DEF_AXIS_FRACTION_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_a_center,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_a_axis0,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_a_axis1,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_a_axis2,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_a_half_lengths,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_b_center,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_b_axis0,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_b_axis1,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_b_axis2,
   input  wire logic [3*COMPONENT_WIDTH-1:0] req_b_half_lengths,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_overlap
);
   import obb_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   pipe_ctrl_type         ctrl;

   // Stage advance: empty stage or successor moving
   always_comb begin
      ctrl.adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int s = NUM_STAGES-2; s >= 0; s--)
         ctrl.adv[s] = !valid_ff[s] || ctrl.adv[s+1];
   end

   // Valid bits travel with their word
   always_comb begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (!ctrl.adv[s])
            valid_in[s] = valid_ff[s];
         else if (s == 0)
            valid_in[s] = req_valid;
         else
            valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ctrl.adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   obb_core #(
      .COMPONENT_WIDTH   (COMPONENT_WIDTH),
      .AXIS_FRACTION_BITS(AXIS_FRACTION_BITS)
   ) u_core (
      .clock         (clock),
      .ctrl          (ctrl),
      .a_center      (req_a_center),
      .a_axis0       (req_a_axis0),
      .a_axis1       (req_a_axis1),
      .a_axis2       (req_a_axis2),
      .a_half_lengths(req_a_half_lengths),
      .b_center      (req_b_center),
      .b_axis0       (req_b_axis0),
      .b_axis1       (req_b_axis1),
      .b_axis2       (req_b_axis2),
      .b_half_lengths(req_b_half_lengths),
      .overlap       (rsp_overlap)
   );

endmodule
`default_nettype wire

// ===== hdl/obb_overlap_checker.sv =====
// Port-level checks for obb_overlap_test, attached by bind.
// Depends on obb_pkg, which it imports.
`default_nettype none
module obb_overlap_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_overlap
);
   import obb_pkg::*;

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped under stall");

   // and its value holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_overlap))
      else $error("rsp word changed under stall");

   // input backs up only when the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with output free");

   // pipeline empty and open after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind obb_overlap_test obb_overlap_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_overlap(rsp_overlap)
);
`default_nettype wire
